// ===== hw/rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, codes and types of the first-fit range allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffra_pkg;

  localparam int unsigned POOL_UNITS = 524288;
  localparam int unsigned FREE_SLOTS = 32;

  localparam int unsigned SIZE_W     = 20;
  localparam int unsigned OFF_W      = 19;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned FREE_ENT_W = 6;
  localparam int unsigned START_W    = 20;
  localparam int unsigned LEN_W      = 21;
  localparam int unsigned SUM_W      = 23;

  // ranges never reach past this unit
  localparam logic [LEN_W-1:0] ADDR_LIMIT = LEN_W'(1048576);

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    WR_COPY,
    WR_TRIM,
    WR_NEW,
    WR_MERGE_PREV,
    WR_MERGE_BOTH,
    WR_MERGE_NEXT
  } wr_sel_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cap_prev;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    set_grant;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_zero;
    logic fit;
    logic trim_zero;
    logic after;
    logic join_prev;
    logic join_next;
    logic full;
    logic out_busy;
  } sts_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [START_W-1:0] start,
                                                  input logic [SUM_W-1:0] sum);
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] res;
    room = ADDR_LIMIT - {1'b0, start};
    if (sum > SUM_W'(room)) begin
      res = room;
    end else begin
      res = sum[LEN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ffra_datapath.sv =====
// ----------------------------------------------------------------------------
// ffra_datapath
// Free range table, request and result registers, compare and merge logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffra_datapath #(
  parameter int unsigned PoolUnits = ffra_pkg::POOL_UNITS,
  parameter int unsigned FreeSlots = ffra_pkg::FREE_SLOTS,
  localparam int unsigned AW = $clog2(FreeSlots),
  localparam int unsigned CW = $clog2(FreeSlots + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_i,
  input  logic [ffra_pkg::SIZE_W-1:0]      block_size_i,
  input  logic [ffra_pkg::OFF_W-1:0]       block_offset_i,
  output logic [ffra_pkg::STAT_W-1:0]      status_o,
  output logic [ffra_pkg::OFF_W-1:0]       granted_offset_o,
  output logic [ffra_pkg::FREE_ENT_W-1:0]  free_entries_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  ffra_pkg::cmd_t                   cmd_i,
  input  logic [AW-1:0]                    rd_addr_i,
  input  logic [AW-1:0]                    wr_addr_i,
  output ffra_pkg::sts_t                   sts_o,
  output logic [CW-1:0]                    count_o,
  output logic [AW-1:0]                    raddr_o
);
  import ffra_pkg::*;

  localparam logic [LEN_W-1:0] ResetLen   = LEN_W'(PoolUnits);
  localparam logic [CW-1:0]    SlotsCount = CW'(FreeSlots);

  // request
  logic               op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [OFF_W-1:0]   off_q;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   in_len;

  // table
  entry_t             mem [FreeSlots];
  entry_t             rdata_q;
  logic               e0_fix_q;
  logic               e0_valid_q;
  logic [AW-1:0]      raddr_q;
  entry_t             cur;
  entry_t             wdata;

  entry_t             prev_q;
  logic               has_prev_q;
  logic [CW-1:0]      count_q;

  status_e            st_q;
  logic [OFF_W-1:0]   grant_q;

  logic                  out_valid_q;
  logic [STAT_W-1:0]     out_status_q;
  logic [OFF_W-1:0]      out_grant_q;
  logic [FREE_ENT_W-1:0] out_free_q;

  logic [CW+FREE_ENT_W-1:0] count_ext;
  logic [LEN_W-1:0]   prev_end;
  logic [LEN_W-1:0]   new_end;
  logic [LEN_W-1:0]   trim_start;
  logic [SUM_W-1:0]   sum_prev;
  logic [SUM_W-1:0]   sum_both;
  logic [SUM_W-1:0]   sum_next;

  assign in_len = clamp_len({1'b0, block_offset_i}, {3'b000, block_size_i});

  // entry 0 reads as the whole pool until it is first written
  always_comb begin
    if (e0_fix_q) begin
      cur.start = '0;
      cur.len   = ResetLen;
    end else begin
      cur = rdata_q;
    end
  end

  assign prev_end   = {1'b0, prev_q.start} + prev_q.len;
  assign new_end    = {2'b00, off_q} + len_q;
  assign trim_start = {1'b0, cur.start} + {1'b0, size_q};
  assign sum_prev   = {2'b00, prev_q.len} + {2'b00, len_q};
  assign sum_both   = sum_prev + {2'b00, cur.len};
  assign sum_next   = {2'b00, len_q} + {2'b00, cur.len};

  always_comb begin
    wdata = cur;
    case (cmd_i.wr_sel)
      WR_COPY: begin
        wdata = cur;
      end
      WR_TRIM: begin
        wdata.start = trim_start[START_W-1:0];
        wdata.len   = cur.len - {1'b0, size_q};
      end
      WR_NEW: begin
        wdata.start = {1'b0, off_q};
        wdata.len   = len_q;
      end
      WR_MERGE_PREV: begin
        wdata.start = prev_q.start;
        wdata.len   = clamp_len(prev_q.start, sum_prev);
      end
      WR_MERGE_BOTH: begin
        wdata.start = prev_q.start;
        wdata.len   = clamp_len(prev_q.start, sum_both);
      end
      WR_MERGE_NEXT: begin
        wdata.start = {1'b0, off_q};
        wdata.len   = clamp_len({1'b0, off_q}, sum_next);
      end
      default: begin
        wdata = cur;
      end
    endcase
  end

  always_comb begin
    sts_o.is_free   = op_q;
    sts_o.free_zero = (len_q == '0);
    sts_o.fit       = ({1'b0, size_q} <= cur.len);
    sts_o.trim_zero = (cur.len == {1'b0, size_q});
    sts_o.after     = (cur.start > {1'b0, off_q});
    sts_o.join_prev = has_prev_q && (prev_end == {2'b00, off_q});
    sts_o.join_next = (new_end == {1'b0, cur.start});
    sts_o.full      = (count_q == SlotsCount);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign count_o   = count_q;
  assign raddr_o   = raddr_q;
  assign count_ext = {{FREE_ENT_W{1'b0}}, count_q};

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q  <= mem[rd_addr_i];
      raddr_q  <= rd_addr_i;
      e0_fix_q <= (rd_addr_i == '0) && !e0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_valid_q  <= 1'b0;
      has_prev_q  <= 1'b0;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && (wr_addr_i == '0)) begin
        e0_valid_q <= 1'b1;
      end
      if (cmd_i.load_req) begin
        has_prev_q <= 1'b0;
      end else if (cmd_i.cap_prev) begin
        has_prev_q <= 1'b1;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q    <= op_i;
      size_q  <= block_size_i;
      off_q   <= block_offset_i;
      len_q   <= in_len;
      grant_q <= '0;
    end else if (cmd_i.set_grant) begin
      grant_q <= cur.start[OFF_W-1:0];
    end
    if (cmd_i.cap_prev) begin
      prev_q <= cur;
    end
    if (cmd_i.set_status) begin
      st_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
      out_grant_q  <= (st_q == ST_DONE) ? grant_q : '0;
      out_free_q   <= count_ext[FREE_ENT_W-1:0];
    end
  end

  assign status_o         = out_status_q;
  assign granted_offset_o = out_grant_q;
  assign free_entries_o   = out_free_q;
  assign out_valid_o      = out_valid_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotsCount) else $error("free range count above table size");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> count_q != '0) else $error("range removed from empty table");

  a_inc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.cnt_inc && cmd_i.cnt_dec)) else $error("count raised and lowered at once");

  a_rw_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en && cmd_i.wr_en |-> rd_addr_i != wr_addr_i)
    else $error("table read and write collide");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before transaction");

endmodule

// ===== hw/rtl/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer for table scans, entry shifts, merges and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffra_ctrl #(
  parameter int unsigned FreeSlots = ffra_pkg::FREE_SLOTS,
  localparam int unsigned AW = $clog2(FreeSlots),
  localparam int unsigned CW = $clog2(FreeSlots + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffra_pkg::sts_t sts_i,
  input  logic [CW-1:0]  count_i,
  input  logic [AW-1:0]  raddr_i,
  output ffra_pkg::cmd_t cmd_o,
  output logic [AW-1:0]  rd_addr_o,
  output logic [AW-1:0]  wr_addr_o
);
  import ffra_pkg::*;

  localparam int unsigned XW = CW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_FSCAN = 4'd3;
  localparam logic [3:0] S_FEND  = 4'd4;
  localparam logic [3:0] S_SHDN  = 4'd5;
  localparam logic [3:0] S_SHUP  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;

  logic [XW-1:0] raddr_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] rem_next;
  logic [XW-1:0] rem_two;
  logic [AW-1:0] last_addr;
  logic          rem_more;

  assign raddr_x   = XW'(raddr_i);
  assign count_x   = XW'(count_i);
  assign rem_next  = raddr_x + XW'(1);
  assign rem_two   = raddr_x + XW'(2);
  assign rem_more  = (rem_next < count_x);
  assign last_addr = raddr_i - AW'(1);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    cmd_o     = '0;
    rd_addr_o = '0;
    wr_addr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_START;
        end
      end
      S_START: begin
        if (!sts_i.is_free) begin
          if (count_i == '0) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NOFIT;
            state_d          = S_FIN;
          end else begin
            cmd_o.rd_en = 1'b1;
            idx_d       = CW'(1);
            state_d     = S_ASCAN;
          end
        end else if (sts_i.free_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DONE;
          state_d          = S_FIN;
        end else if (count_i == '0) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_NEW;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DONE;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          idx_d       = CW'(1);
          state_d     = S_FSCAN;
        end
      end
      S_ASCAN: begin
        if (sts_i.fit) begin
          cmd_o.set_grant  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DONE;
          if (!sts_i.trim_zero) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_TRIM;
            wr_addr_o    = raddr_i;
            state_d      = S_FIN;
          end else if (rem_more) begin
            // range used up: close the gap above it
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = rem_next[AW-1:0];
            idx_d       = rem_two[CW-1:0];
            state_d     = S_SHDN;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_FIN;
          end
        end else if (idx_q == count_i) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOFIT;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = idx_q[AW-1:0];
          idx_d       = idx_q + CW'(1);
        end
      end
      S_FSCAN: begin
        if (sts_i.after) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DONE;
          if (sts_i.join_prev && sts_i.join_next) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_MERGE_BOTH;
            wr_addr_o    = last_addr;
            if (rem_more) begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = rem_next[AW-1:0];
              idx_d       = rem_two[CW-1:0];
              state_d     = S_SHDN;
            end else begin
              cmd_o.cnt_dec = 1'b1;
              state_d       = S_FIN;
            end
          end else if (sts_i.join_prev) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_MERGE_PREV;
            wr_addr_o    = last_addr;
            state_d      = S_FIN;
          end else if (sts_i.join_next) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_MERGE_NEXT;
            wr_addr_o    = raddr_i;
            state_d      = S_FIN;
          end else if (sts_i.full) begin
            cmd_o.status = ST_FULL;
            state_d      = S_FIN;
          end else begin
            // open a slot at the insert point, top entry first
            cmd_o.set_status = 1'b0;
            cmd_o.rd_en      = 1'b1;
            rd_addr_o        = count_i[AW-1:0] - AW'(1);
            pos_d            = CW'(raddr_i);
            state_d          = S_SHUP;
          end
        end else begin
          cmd_o.cap_prev = 1'b1;
          if (idx_q == count_i) begin
            state_d = S_FEND;
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = idx_q[AW-1:0];
            idx_d       = idx_q + CW'(1);
          end
        end
      end
      S_FEND: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_DONE;
        state_d          = S_FIN;
        if (sts_i.join_prev) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_MERGE_PREV;
          wr_addr_o    = raddr_i;
        end else if (sts_i.full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_NEW;
          cmd_o.cnt_inc = 1'b1;
          wr_addr_o     = count_i[AW-1:0];
        end
      end
      S_SHDN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_COPY;
        wr_addr_o    = last_addr;
        if (idx_q < count_i) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = idx_q[AW-1:0];
          idx_d       = idx_q + CW'(1);
        end else begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DONE;
          state_d          = S_FIN;
        end
      end
      S_SHUP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_COPY;
        wr_addr_o    = raddr_i + AW'(1);
        if (raddr_x > XW'(pos_q)) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = last_addr;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_sel     = WR_NEW;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_DONE;
        wr_addr_o        = pos_q[AW-1:0];
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/first_fit_range_allocator.sv =====
// one request in flight: the wait for a result grows with the free ranges held,
// and the next request is taken once the result is loaded into the output
// register, later while out_ready_i is low
// the wait is set by the table: one entry read and one written per cycle for
// the first-fit scan and for shifting entries on insert or removal
// reset: one free range covering the whole pool, no clearing pass
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator over a sorted table of free ranges with coalescing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_range_allocator #(
  parameter int unsigned PoolUnits = ffra_pkg::POOL_UNITS,
  parameter int unsigned FreeSlots = ffra_pkg::FREE_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [ffra_pkg::SIZE_W-1:0]      block_size_i,
  input  logic [ffra_pkg::OFF_W-1:0]       block_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ffra_pkg::STAT_W-1:0]      status_o,
  output logic [ffra_pkg::OFF_W-1:0]       granted_offset_o,
  output logic [ffra_pkg::FREE_ENT_W-1:0]  free_entries_o
);
  import ffra_pkg::*;

  localparam int unsigned AW = $clog2(FreeSlots);
  localparam int unsigned CW = $clog2(FreeSlots + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] count;
  logic [AW-1:0] raddr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  ffra_ctrl #(
    .FreeSlots (FreeSlots)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .count_i    (count),
    .raddr_i    (raddr),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  ffra_datapath #(
    .PoolUnits (PoolUnits),
    .FreeSlots (FreeSlots)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_i),
    .block_size_i     (block_size_i),
    .block_offset_i   (block_offset_i),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .free_entries_o   (free_entries_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .wr_addr_i        (wr_addr),
    .sts_o            (sts),
    .count_o          (count),
    .raddr_o          (raddr)
  );

endmodule
